FILE: rtl/urdr_pkg.sv
`timescale 1ns / 1ps

package urdr_pkg;

    // Command codes
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_DRAW   = 2'd1;
    localparam logic [1:0] OP_REWIND = 2'd2;

    // Result status codes
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_DEPLETED = 1'b1;

    // Fixed field widths
    localparam int unsigned VALUE_W     = 32;
    localparam int unsigned BOUND_W     = 33;
    localparam int unsigned LEFT_CNT_W  = 5;

    typedef struct packed {
        logic [1:0]         op;
        logic [7:0]         data_byte;
        logic [BOUND_W-1:0] max_value;
    } cmd_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               status;
    } result_t;

endpackage

FILE: rtl/urdr_ram.sv
`timescale 1ns / 1ps

module urdr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/uniform_range_draw_with_recycling.sv
`timescale 1ns / 1ps

// Uniform integer draw from a store of entropy bytes, with rejection sampling
// and recycling of the rejected excess.
//
// Command channel (cmd_valid / cmd_stall / cmd): op 0 appends data_byte to the
// store (dropped once full), op 2 rewinds the read position and clears the
// leftover bits, op 1 draws a value below max_value. Appends and rewinds are
// taken while idle and give no result. A draw gives one item on the result channel
// (result_valid / result_stall / result): the value, or status depleted with
// value zero when the source runs out of bits.
// A draw first sizes itself from the bound by a binary search; each try then
// ends depleted if too few bits remain, else takes leftover bits and, when
// fresh bits are needed, reads the one to five bytes it touches through the
// single read port; a rejected try adds a scan of the excess subranges; the
// result is then loaded into the output register. cmd_stall is high from
// acceptance of a draw until then.
// The result sits in an output register, so appends and rewinds keep flowing
// while the receiver stalls; a second draw waits at the end for the register.
// Reset clears position, fill count, leftovers and the result valid flag; the
// byte store is not cleared and needs no clearing pass.

module uniform_range_draw_with_recycling #(
    parameter int unsigned STORE_BYTES = 4096,
    parameter int unsigned DRAW_BITS   = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_stall,
    input  urdr_pkg::cmd_t    cmd,
    output logic             result_valid,
    input  logic             result_stall,
    output urdr_pkg::result_t result
);

    import urdr_pkg::*;

    localparam int unsigned DW    = DRAW_BITS;
    localparam int unsigned CW    = $clog2(DRAW_BITS + 1);   // bit counts 0..DW
    localparam int unsigned LW    = $clog2(STORE_BYTES + 1); // fill count
    localparam int unsigned PW    = $clog2(8 * STORE_BYTES + 1); // bit position
    localparam int unsigned AW    = $clog2(STORE_BYTES);
    localparam int unsigned WB    = (DRAW_BITS + 14) / 8;    // bytes in a window
    localparam int unsigned KW    = $clog2(WB + 1);
    localparam int unsigned LOG_W = $clog2(DRAW_BITS);
    localparam int unsigned STEP0 = 2 ** (LOG_W - 1);
    localparam int unsigned RW    = LEFT_CNT_W;

    typedef enum logic [10:0] {
        ST_IDLE    = 11'b000_0000_0001,
        ST_NEED    = 11'b000_0000_0010,
        ST_TRY     = 11'b000_0000_0100,
        ST_LEFT    = 11'b000_0000_1000,
        ST_FETCH   = 11'b000_0001_0000,
        ST_EXTRACT = 11'b000_0010_0000,
        ST_MERGE   = 11'b000_0100_0000,
        ST_CHECK   = 11'b000_1000_0000,
        ST_EXCESS  = 11'b001_0000_0000,
        ST_SCAN    = 11'b010_0000_0000,
        ST_DONE    = 11'b100_0000_0000
    } state_t;

    function automatic logic [DW-1:0] low_mask(input logic [CW-1:0] n);
        low_mask = ~({DW{1'b1}} << n);
    endfunction

    // control state
    state_t          state_reg, state_next;
    logic [LW-1:0]   loaded_reg, loaded_next;
    logic [PW-1:0]   pos_reg, pos_next;
    logic [DW-1:0]   rb_reg, rb_next;        // leftover bits
    logic [RW-1:0]   rc_reg, rc_next;        // leftover count
    logic            res_valid_reg, res_valid_next;
    logic [KW-1:0]   issue_k_reg, issue_k_next;
    logic            pend_reg, pend_next;

    // datapath
    logic [DW:0]     m_reg, m_next;
    logic [DW-1:0]   x_reg, x_next;
    logic [CW-1:0]   n_reg, n_next;
    logic [CW-1:0]   step_reg, step_next;
    logic [CW-1:0]   need_reg, need_next;
    logic [CW-1:0]   fl_reg, fl_next;
    logic [CW-1:0]   rest_reg, rest_next;
    logic [2:0]      shift_reg, shift_next;
    logic [PW-4:0]   base_reg, base_next;
    logic [KW-1:0]   nbytes_reg, nbytes_next;
    logic [KW-1:0]   pend_k_reg, pend_k_next;
    logic [WB*8-1:0] win_reg, win_next;
    logic [DW-1:0]   src_reg, src_next;
    logic [DW-1:0]   v_reg, v_next;
    logic            status_reg, status_next;
    logic [DW-1:0]   lm_reg, lm_next;
    logic [DW-1:0]   sub_reg, sub_next;
    logic [CW-1:0]   idx_reg, idx_next;
    result_t         res_reg, res_next;

    // combinational helpers
    logic            accept;
    logic            store_we;
    logic [DW:0]     full;
    logic [DW:0]     m_clamp;
    logic [DW:0]     m_dec;
    logic [DW-1:0]   x_shift;
    logic [PW:0]     need_end;
    logic [PW:0]     have_end;
    logic [5:0]      need6;
    logic [5:0]      rc6;
    logic [5:0]      fl6;
    logic [CW+1:0]   span;
    logic [PW-4:0]   rd_byte;
    logic [AW-1:0]   ram_raddr;
    logic [7:0]      ram_rdata;
    logic            issuing;
    logic [WB*8-1:0] win_shift;
    logic [DW+1:0]   diff;
    logic [DW:0]     lm_full;
    logic            out_free;

    assign accept   = cmd_valid && !cmd_stall;
    assign store_we = accept && (cmd.op == OP_APPEND) && (loaded_reg < LW'(STORE_BYTES));

    // Bound clamp: zero or beyond full range means full range.
    assign full    = (DW + 1)'(1) << DW;
    assign m_clamp = ((cmd.max_value == '0) || (cmd.max_value > BOUND_W'(full)))
                     ? full : cmd.max_value[DW:0];
    assign m_dec   = m_clamp - (DW + 1)'(1);

    assign x_shift  = x_reg >> step_reg;
    assign need_end = (PW + 1)'(pos_reg) + (PW + 1)'(need_reg);
    assign have_end = (PW + 1)'({loaded_reg, 3'b000}) + (PW + 1)'(rc_reg);
    assign need6    = 6'(need_reg);
    assign rc6      = 6'(rc_reg);
    assign fl6      = (need6 < rc6) ? need6 : rc6;
    assign span     = (CW + 2)'(pos_reg[2:0]) + (CW + 2)'(rest_reg) + (CW + 2)'(7);
    assign rd_byte  = base_reg + (PW - 3)'(issue_k_reg);
    assign ram_raddr = rd_byte[AW-1:0];
    assign issuing  = issue_k_reg < nbytes_reg;
    assign win_shift = win_reg >> shift_reg;
    assign diff     = (DW + 2)'(v_reg) - (DW + 2)'(m_reg);
    assign lm_full  = ((DW + 1)'(1) << need_reg) - m_reg;
    assign out_free = !res_valid_reg || !result_stall;

    urdr_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (loaded_reg[AW-1:0]),
        .wdata (cmd.data_byte),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        loaded_next    = loaded_reg;
        pos_next       = pos_reg;
        rb_next        = rb_reg;
        rc_next        = rc_reg;
        res_valid_next = res_valid_reg;
        issue_k_next   = issue_k_reg;
        pend_next      = pend_reg;
        m_next         = m_reg;
        x_next         = x_reg;
        n_next         = n_reg;
        step_next      = step_reg;
        need_next      = need_reg;
        fl_next        = fl_reg;
        rest_next      = rest_reg;
        shift_next     = shift_reg;
        base_next      = base_reg;
        nbytes_next    = nbytes_reg;
        pend_k_next    = pend_k_reg;
        win_next       = win_reg;
        src_next       = src_reg;
        v_next         = v_reg;
        status_next    = status_reg;
        lm_next        = lm_reg;
        sub_next       = sub_reg;
        idx_next       = idx_reg;
        res_next       = res_reg;

        if (res_valid_reg && !result_stall)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.op)
                        OP_APPEND:
                        begin
                            if (store_we)
                            begin
                                loaded_next = loaded_reg + LW'(1);
                            end
                        end
                        OP_DRAW:
                        begin
                            m_next     = m_clamp;
                            x_next     = m_dec[DW-1:0];
                            n_next     = '0;
                            step_next  = CW'(STEP0);
                            state_next = ST_NEED;
                        end
                        OP_REWIND:
                        begin
                            pos_next = '0;
                            rb_next  = '0;
                            rc_next  = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // Bit length of m-1 by binary search on the shifter.
            ST_NEED:
            begin
                if (x_shift != '0)
                begin
                    x_next = x_shift;
                    n_next = n_reg + step_reg;
                end
                step_next = step_reg >> 1;
                if (step_reg == CW'(1))
                begin
                    need_next  = (x_next != '0) ? n_next + CW'(1) : '0;
                    state_next = ST_TRY;
                end
            end

            ST_TRY:
            begin
                if (need_end > have_end)
                begin
                    v_next      = '0;
                    status_next = STATUS_DEPLETED;
                    state_next  = ST_DONE;
                end
                else
                begin
                    fl_next    = CW'(fl6);
                    rest_next  = need_reg - CW'(fl6);
                    state_next = ST_LEFT;
                end
            end

            // Leftovers give the high part of the candidate.
            ST_LEFT:
            begin
                v_next       = rb_reg & low_mask(fl_reg);
                rb_next      = rb_reg >> fl_reg;
                rc_next      = rc_reg - RW'(fl_reg);
                shift_next   = pos_reg[2:0];
                base_next    = pos_reg[PW-1:3];
                nbytes_next  = KW'(span >> 3);
                issue_k_next = '0;
                pend_next    = 1'b0;
                win_next     = '0;
                state_next   = (rest_reg == '0) ? ST_CHECK : ST_FETCH;
            end

            // One byte read issued per cycle, its data lands in the next cycle.
            ST_FETCH:
            begin
                if (pend_reg)
                begin
                    win_next[pend_k_reg*8 +: 8] = ram_rdata;
                end
                pend_next   = issuing;
                pend_k_next = issue_k_reg;
                if (issuing)
                begin
                    issue_k_next = issue_k_reg + KW'(1);
                end
                else if (pend_reg)
                begin
                    state_next = ST_EXTRACT;
                end
            end

            ST_EXTRACT:
            begin
                src_next   = win_shift[DW-1:0] & low_mask(rest_reg);
                pos_next   = pos_reg + PW'(rest_reg);
                state_next = ST_MERGE;
            end

            ST_MERGE:
            begin
                v_next     = (v_reg << rest_reg) | src_reg;
                state_next = ST_CHECK;
            end

            ST_CHECK:
            begin
                if (diff[DW+1])
                begin
                    rb_next     = '0;
                    rc_next     = '0;
                    status_next = STATUS_OK;
                    state_next  = ST_DONE;
                end
                else
                begin
                    v_next     = diff[DW-1:0];
                    state_next = ST_EXCESS;
                end
            end

            ST_EXCESS:
            begin
                lm_next    = lm_full[DW-1:0];
                sub_next   = DW'(1);
                idx_next   = '0;
                state_next = ST_SCAN;
            end

            // Walk the excess subranges from the smallest power of two up.
            ST_SCAN:
            begin
                lm_next  = lm_reg >> 1;
                sub_next = sub_reg << 1;
                idx_next = idx_reg + CW'(1);
                if (lm_reg[0])
                begin
                    if (v_reg >= sub_reg)
                    begin
                        v_next = v_reg - sub_reg;
                    end
                    else
                    begin
                        if (idx_reg != '0)
                        begin
                            rb_next = v_reg;
                            rc_next = rc_reg + RW'(idx_reg);
                        end
                        state_next = ST_TRY;
                    end
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    res_next.value  = VALUE_W'(v_reg);
                    res_next.status = status_reg;
                    res_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            loaded_reg    <= '0;
            pos_reg       <= '0;
            rb_reg        <= '0;
            rc_reg        <= '0;
            res_valid_reg <= 1'b0;
            issue_k_reg   <= '0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            loaded_reg    <= loaded_next;
            pos_reg       <= pos_next;
            rb_reg        <= rb_next;
            rc_reg        <= rc_next;
            res_valid_reg <= res_valid_next;
            issue_k_reg   <= issue_k_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg      <= m_next;
        x_reg      <= x_next;
        n_reg      <= n_next;
        step_reg   <= step_next;
        need_reg   <= need_next;
        fl_reg     <= fl_next;
        rest_reg   <= rest_next;
        shift_reg  <= shift_next;
        base_reg   <= base_next;
        nbytes_reg <= nbytes_next;
        pend_k_reg <= pend_k_next;
        win_reg    <= win_next;
        src_reg    <= src_next;
        v_reg      <= v_next;
        status_reg <= status_next;
        lm_reg     <= lm_next;
        sub_reg    <= sub_next;
        idx_reg    <= idx_next;
        res_reg    <= res_next;
    end

    assign cmd_stall    = (state_reg != ST_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // Fill count stays within the store.
    a_loaded_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (PW + 1)'(loaded_reg) <= (PW + 1)'(STORE_BYTES))
        else $error("fill count beyond store size");

    // Read position never passes the loaded bits.
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (PW + 1)'(pos_reg) <= (PW + 1)'({loaded_reg, 3'b000}))
        else $error("read position beyond loaded bytes");

    // A new result only comes out of the completion state.
    a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside completion");

    // A depleted draw reports zero.
    a_depleted_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (res_reg.status == STATUS_DEPLETED)) |-> (res_reg.value == '0))
        else $error("depleted result with nonzero value");

    // Store reads never run past the bytes needed for the try.
    a_fetch_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH) |-> (issue_k_reg <= nbytes_reg))
        else $error("fetch count overrun");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

// Testbench for uniform_range_draw_with_recycling.
module tb;

    import urdr_pkg::*;

    // Widths and sizes of the block as instantiated (default parameters)
    localparam int unsigned STORE_BYTES   = 4096;
    localparam logic [63:0] FULL_RANGE    = 64'h1_0000_0000;

    // Op code the block ignores; it has no name in the package
    localparam logic [1:0]  OP_UNUSED     = 2'd3;

    // Run shape
    localparam int unsigned RAND_ITEMS    = 1600;
    localparam int unsigned DRAIN_TAIL    = 6;
    localparam int unsigned HOLD_CYCLES   = 400;
    // each rejected try adds a store fetch and a subrange scan, and a draw can retry a few times
    localparam int unsigned SETTLE_CYCLES = 200;

    // Directed table: an item, and a result typed in by hand where it is obvious
    typedef struct packed {
        cmd_t    c;
        logic    fixed;
        result_t want;
    } plan_row_t;

    localparam int PLAN_ROWS = 24;

    plan_row_t plan [PLAN_ROWS] = '{
        // empty store straight after reset
        '{'{OP_DRAW,   8'h00, 33'd2},           1'b1, '{32'd0, STATUS_DEPLETED}},
        '{'{OP_DRAW,   8'h00, 33'd1},           1'b1, '{32'd0, STATUS_OK}},
        '{'{OP_DRAW,   8'h00, 33'd0},           1'b1, '{32'd0, STATUS_DEPLETED}},
        '{'{OP_DRAW,   8'hff, 33'h1_ffff_ffff}, 1'b1, '{32'd0, STATUS_DEPLETED}},
        // a handful of bytes with strong bit patterns
        '{'{OP_APPEND, 8'hff, 33'd0},           1'b0, '0},
        '{'{OP_APPEND, 8'h00, 33'h1_ffff_ffff}, 1'b0, '0},
        '{'{OP_APPEND, 8'ha5, 33'd0},           1'b0, '0},
        '{'{OP_APPEND, 8'h3c, 33'd0},           1'b0, '0},
        '{'{OP_APPEND, 8'h5a, 33'd0},           1'b0, '0},
        '{'{OP_APPEND, 8'hc3, 33'd0},           1'b0, '0},
        '{'{OP_APPEND, 8'h0f, 33'd0},           1'b0, '0},
        '{'{OP_APPEND, 8'h81, 33'd0},           1'b0, '0},
        // full range, then small bounds that reject and recycle
        '{'{OP_DRAW,   8'h00, 33'h1_0000_0000}, 1'b0, '0},
        '{'{OP_DRAW,   8'h00, 33'd5},           1'b0, '0},
        '{'{OP_DRAW,   8'h00, 33'd3},           1'b0, '0},
        '{'{OP_DRAW,   8'h00, 33'd7},           1'b0, '0},
        '{'{OP_UNUSED, 8'hff, 33'h1_ffff_ffff}, 1'b0, '0},
        '{'{OP_REWIND, 8'h00, 33'd0},           1'b0, '0},
        // just over half the 32-bit range: about half of all tries reject
        '{'{OP_DRAW,   8'h00, 33'h0_8000_0001}, 1'b0, '0},
        '{'{OP_REWIND, 8'h00, 33'd0},           1'b0, '0},
        '{'{OP_DRAW,   8'h00, 33'd9},           1'b0, '0},
        '{'{OP_DRAW,   8'h00, 33'd1},           1'b1, '{32'd0, STATUS_OK}},
        '{'{OP_DRAW,   8'h00, 33'd17},          1'b0, '0},
        '{'{OP_DRAW,   8'h00, 33'h1_0000_0000}, 1'b0, '0}
    };

    logic    clk;
    logic    rst_n;
    logic    cmd_valid;
    logic    cmd_stall;
    cmd_t    cmd;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    // Shadow of the block's state, advanced at each accepted item
    logic [7:0]  pool_bytes [STORE_BYTES];
    int unsigned pool_fill  = 0;
    int unsigned pool_pos   = 0;
    logic [31:0] spare_bits = '0;
    int unsigned spare_cnt  = 0;

    // Draw results still owed by the block, oldest first
    result_t     due_draws [$];

    int unsigned errors      = 0;
    int unsigned items_sent  = 0;
    int unsigned idle_pct    = 0;
    int unsigned stall_pct   = 0;
    logic        hold_go     = 1'b0;
    logic        hold_done   = 1'b0;

    // scratch for the stimulus process
    int unsigned rand_start;
    int unsigned done_frac;
    int unsigned roll;
    int unsigned n_app;
    int unsigned n_draw;
    int unsigned drain_tail;
    cmd_t        cmd_next;
    result_t     head_draw;

    uniform_range_draw_with_recycling dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int unsigned bit_len(input logic [63:0] x);
        int unsigned n;
        n = 0;
        while (x != 64'd0)
        begin
            n++;
            x = x >> 1;
        end
        return n;
    endfunction

    // n fresh bits from the byte pool, LSB first; bytes not yet loaded read as zero
    function automatic logic [63:0] fresh_bits(input int unsigned n);
        logic [63:0] window;
        int unsigned first;
        int unsigned k;
        first  = pool_pos >> 3;
        window = '0;
        for (k = 0; k < 5; k++)
            if (first + k < pool_fill)
                window |= {56'd0, pool_bytes[first + k]} << (8 * k);
        window   = window >> (pool_pos & 7);
        pool_pos = pool_pos + n;
        return window & ((64'd1 << n) - 64'd1);
    endfunction

    // One draw: leftovers form the high part, fresh bits the low part. A reject
    // is reduced to its power-of-two subrange, whose spare bits are kept for the
    // next try. Gives up with depleted once fewer bits remain than one try needs.
    function automatic void predict_draw(input logic [32:0] bound, output result_t r);
        logic [63:0] m;
        logic [63:0] v;
        logic [63:0] lm;
        logic [63:0] sub;
        int unsigned avail;
        int unsigned need;
        int unsigned from_left;
        int unsigned rest;
        logic        settled;
        m = {31'd0, bound};
        if (m == 64'd0 || m > FULL_RANGE)
            m = FULL_RANGE;
        need    = bit_len(m - 64'd1);
        settled = 1'b0;
        r       = '0;
        while (!settled)
        begin
            avail = pool_fill * 8 + spare_cnt - pool_pos;
            if (need > avail)
            begin
                // state keeps whatever earlier tries left behind
                r.value  = '0;
                r.status = STATUS_DEPLETED;
                settled  = 1'b1;
            end
            else
            begin
                from_left = (need < spare_cnt) ? need : spare_cnt;
                v = '0;
                if (from_left > 0)
                begin
                    v          = {32'd0, spare_bits} & ((64'd1 << from_left) - 64'd1);
                    spare_bits = spare_bits >> from_left;
                    spare_cnt  = spare_cnt - from_left;
                end
                rest = need - from_left;
                if (rest > 0)
                    v = (v << rest) | fresh_bits(rest);
                if (v < m)
                begin
                    spare_bits = '0;
                    spare_cnt  = 0;
                    r.value    = v[31:0];
                    r.status   = STATUS_OK;
                    settled    = 1'b1;
                end
                else
                begin
                    v   = v - m;
                    lm  = (64'd1 << need) - m;
                    sub = lm & (~lm + 64'd1);
                    while (v >= sub && lm != 64'd0)
                    begin
                        v   = v - sub;
                        lm  = lm - sub;
                        sub = lm & (~lm + 64'd1);
                    end
                    // old unused leftovers are overwritten, the count still grows
                    if (sub > 64'd1)
                    begin
                        spare_bits = v[31:0];
                        spare_cnt  = (spare_cnt + bit_len(sub - 64'd1)) & 31;
                    end
                end
            end
        end
    endfunction

    // Advance the shadow state by one item; returns 1 when a result is owed
    function automatic logic apply_cmd(input cmd_t c, output result_t r);
        r = '0;
        apply_cmd = 1'b0;
        case (c.op)
            OP_APPEND:
            begin
                // appends into a full pool are dropped
                if (pool_fill < STORE_BYTES)
                begin
                    pool_bytes[pool_fill] = c.data_byte;
                    pool_fill++;
                end
            end
            OP_DRAW:
            begin
                predict_draw(c.max_value, r);
                apply_cmd = 1'b1;
            end
            OP_REWIND:
            begin
                pool_pos   = 0;
                spare_bits = '0;
                spare_cnt  = 0;
            end
            default: ;
        endcase
    endfunction

    function automatic cmd_t rand_cmd(input logic [1:0] op);
        logic [31:0] w0;
        logic [31:0] w1;
        cmd_t        c;
        w0 = $urandom;
        w1 = $urandom;
        c.op        = op;
        c.data_byte = w0[7:0];
        c.max_value = {w0[8], w1};
        return c;
    endfunction

    // Bounds spread over all widths, with the awkward ones well represented
    function automatic logic [32:0] pick_bound();
        logic [31:0] w;
        logic [32:0] b;
        int unsigned k;
        w = $urandom;
        k = $urandom_range(1, 32);
        case ($urandom_range(0, 7))
            0:       b = {28'd0, 5'($urandom_range(1, 16))};
            1:       b = (33'd1 << (k - 1)) + 33'd1;   // many rejections
            2:       b = 33'd1 << $urandom_range(0, 32);
            3:       b = '0;                            // full range
            4:       b = {1'b1, w};                     // above full range
            default: b = ({1'b0, w} >> (32 - k)) | (33'd1 << (k - 1));
        endcase
        return b;
    endfunction

    // Offer one item (after an optional idle gap), wait for it to be taken, then
    // record what it is owed. Returns at the falling edge after acceptance.
    task automatic issue_cmd(input cmd_t c, input logic fixed, input result_t want);
        result_t drawn;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd       <= c;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        if (apply_cmd(c, drawn))
            due_draws.push_back(fixed ? want : drawn);
        if (c.op != OP_UNUSED)
            items_sent++;
        @(negedge clk);
    endtask

    // Result receiver: random stall at the current rate, plus one long hold-off
    // so that the output register fills and the command side backs up.
    initial
    begin
        result_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_go && !hold_done)
            begin
                hold_done = 1'b1;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
                result_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Result checker: every taken result must match the oldest owed draw
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (due_draws.size() == 0)
            begin
                $error("unexpected result: value %0h status %0b", result.value, result.status);
                errors++;
            end
            else
            begin
                head_draw = due_draws.pop_front();
                if (result.value !== head_draw.value)
                begin
                    $error("value: expected %0h, got %0h", head_draw.value, result.value);
                    errors++;
                end
                if (result.status !== head_draw.status)
                begin
                    $error("status: expected %0b, got %0b", head_draw.status, result.status);
                    errors++;
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd       = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed items, no idling
        foreach (plan[i])
            issue_cmd(plan[i].c, plan[i].fixed, plan[i].want);

        // Random part: mostly bursts of appends followed by a few draws, with
        // rewinds, the odd rewind inside a burst, and ignored ops as noise.
        // The idling mode changes every fifth of the way; the last fifth runs
        // flat out with the long hold-off on the result side.
        rand_start = items_sent;
        while (items_sent - rand_start < RAND_ITEMS)
        begin
            done_frac = (items_sent - rand_start) * 5 / RAND_ITEMS;
            case (done_frac)
                1:       begin idle_pct = 49; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 49; end
                3:       begin idle_pct = 7;  stall_pct = 7;  end
                default: begin idle_pct = 0;  stall_pct = 0;  end
            endcase
            if (done_frac == 4)
                hold_go = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 4)
                issue_cmd(rand_cmd(OP_UNUSED), 1'b0, '0);
            else if (roll < 10)
                issue_cmd(rand_cmd(OP_REWIND), 1'b0, '0);
            else
            begin
                n_app  = $urandom_range(0, 10);
                n_draw = $urandom_range(1, 4);
                repeat (n_app) issue_cmd(rand_cmd(OP_APPEND), 1'b0, '0);
                if ($urandom_range(0, 9) == 0)
                    issue_cmd(rand_cmd(OP_REWIND), 1'b0, '0);
                repeat (n_draw)
                begin
                    cmd_next = rand_cmd(OP_DRAW);
                    cmd_next.max_value = pick_bound();
                    issue_cmd(cmd_next, 1'b0, '0);
                end
            end
        end

        // Rewind, then draw wide values until the loaded bytes are used up:
        // this reaches the last loaded byte and a short run of depleted draws.
        idle_pct  = 7;
        stall_pct = 7;
        issue_cmd(rand_cmd(OP_REWIND), 1'b0, '0);
        drain_tail = DRAIN_TAIL;
        while (drain_tail > 0)
        begin
            cmd_next = rand_cmd(OP_DRAW);
            cmd_next.max_value = {2'b01, cmd_next.max_value[30:0]};
            issue_cmd(cmd_next, 1'b0, '0);
            if (pool_fill * 8 + spare_cnt - pool_pos < 32)
                drain_tail--;
        end
        cmd_valid <= 1'b0;

        while (due_draws.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial
    begin
        #50_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: uniform_range_draw_with_recycling.f
rtl/urdr_pkg.sv
rtl/urdr_ram.sv
rtl/uniform_range_draw_with_recycling.sv
tb/sv/tb.sv
